// ===== design/tmbe_pkg.sv =====
package tmbe_pkg;

  // Tape geometry: the depth is a power of two, so the pointer wraps by masking.
  localparam int unsigned TAPE_AW    = 15;
  localparam int unsigned TAPE_DEPTH = 1 << TAPE_AW;

  // Program geometry: the instruction pointer wraps at the program depth.
  localparam int unsigned PROG_AW    = 16;
  localparam int unsigned PROG_DEPTH = 1 << PROG_AW;

  // Field widths of the channel words.
  localparam int unsigned KIND_W = 4;
  localparam int unsigned OPND_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IP_W   = 16;
  localparam int unsigned STAT_W = 2;

  // Result queue depth and its pointer and count widths.
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PW    = 2;
  localparam int unsigned OUT_CW    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_END      = 4'd0,
    KIND_ADD_BYTE = 4'd1,
    KIND_SUB_BYTE = 4'd2,
    KIND_ADD_PTR  = 4'd3,
    KIND_SUB_PTR  = 4'd4,
    KIND_WRITE    = 4'd5,
    KIND_READ     = 4'd6,
    KIND_JUMP_Z   = 4'd7,
    KIND_JUMP     = 4'd8
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_HALT    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_PTR_OOR = 2'd3
  } status_e;

  typedef struct packed {
    logic [IP_W-1:0]   next_ip;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

endpackage

// ===== design/tmbe_if.sv =====
interface tmbe_in_if import tmbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [OPND_W-1:0] operand;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output kind, output operand, output read_data,
                  input ready);
  modport sink   (input valid, input kind, input operand, input read_data,
                  output ready);
endinterface

interface tmbe_out_if import tmbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IP_W-1:0]   next_ip;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic [STAT_W-1:0] status;

  modport source (output valid, output next_ip, output out_byte, output out_valid,
                  output status, input ready);
  modport sink   (input valid, input next_ip, input out_byte, input out_valid,
                  input status, output ready);
endinterface

// ===== design/tmbe_out_fifo.sv =====
module tmbe_out_fifo import tmbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  output logic [OUT_CW-1:0] count_o,
  tmbe_out_if.source        out_o
);

  result_t           mem_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CW-1:0] cnt_q, cnt_d;
  logic              pop;
  result_t           head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i.valid) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  assign count_o         = cnt_q;
  assign out_o.valid     = (cnt_q != '0);
  assign out_o.next_ip   = head.next_ip;
  assign out_o.out_byte  = head.out_byte;
  assign out_o.out_valid = head.out_valid;
  assign out_o.status    = head.status;

endmodule

// ===== design/tape_machine_bytecode_executor.sv =====
// Tape machine bytecode executor.
//
// in_i carries one fetched instruction word (kind, operand, read_data); out_o
// returns one result word per instruction (next_ip, out_byte, out_valid, status)
// in instruction order. Both channels use valid/ready.
//
// Stage A reads the tape cell under the data pointer and updates the pointer;
// stage B does the cell read-modify-write, the instruction pointer update and
// builds the result for the result queue that drives out_o. A last-write bypass
// covers back-to-back hits on the same cell. Throughput: one instruction per
// cycle while in_i.ready is high, bounded by the single tape write port.
//
// Reset: after rst_ni releases, a clearing pass writes zero to every tape cell,
// one per cycle, TAPE_DEPTH cycles (32768) with in_i.ready low. Pointers start
// at zero.
//
// Stall: results collect in a 3-entry queue; ready depends only on registered
// occupancy, so a stalled receiver never reaches in_i.ready combinationally.
module tape_machine_bytecode_executor import tmbe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  tmbe_in_if.sink    in_i,
  tmbe_out_if.source out_o
);

  // Tape storage and clearing pass
  logic [BYTE_W-1:0]  tape_mem [TAPE_DEPTH];
  logic               clr_q;
  logic [TAPE_AW-1:0] clr_addr_q;

  // Architectural pointers
  logic [TAPE_AW-1:0] data_ptr_q, data_ptr_d;
  logic [PROG_AW-1:0] ip_q, ip_d;

  // Stage B registers
  logic               s1_valid_q;
  kind_e              s1_kind_q;
  logic [OPND_W-1:0]  s1_opnd_q;
  logic [BYTE_W-1:0]  s1_rd_q;
  logic [TAPE_AW-1:0] s1_idx_q;
  logic               s1_oor_q;
  logic [BYTE_W-1:0]  cell_q;

  // Last-write bypass
  logic               fwd_valid_q;
  logic [TAPE_AW-1:0] fwd_addr_q;
  logic [BYTE_W-1:0]  fwd_data_q;

  logic               in_fire;
  kind_e              kind_a;
  logic [OPND_W:0]    ptr_sum;
  logic               add_oor, sub_oor, oor_a;
  logic [OUT_CW-1:0]  fifo_cnt;
  logic [OUT_CW:0]    occupancy;

  logic [BYTE_W-1:0]  cur_byte;
  logic [BYTE_W-1:0]  cell_new;
  logic               cell_we;
  logic [PROG_AW-1:0] ip_inc;
  push_t              push;

  logic               wr_en;
  logic [TAPE_AW-1:0] wr_addr;
  logic [BYTE_W-1:0]  wr_data;

  // Hold ready low while clearing or when the queue could overflow.
  assign occupancy  = {1'b0, fifo_cnt} + {{OUT_CW{1'b0}}, s1_valid_q};
  assign in_i.ready = !clr_q && (occupancy < (OUT_CW + 1)'(OUT_DEPTH));
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------- Stage A: pointer update ----------------
  assign kind_a  = kind_e'(in_i.kind);
  assign ptr_sum = {1'b0, in_i.operand} + (OPND_W + 1)'(data_ptr_q);
  assign add_oor = (ptr_sum >= (OPND_W + 1)'(TAPE_DEPTH));
  assign sub_oor = (in_i.operand > OPND_W'(data_ptr_q));

  always_comb begin
    data_ptr_d = data_ptr_q;
    oor_a      = 1'b0;
    case (kind_a)
      KIND_ADD_PTR: begin
        data_ptr_d = ptr_sum[TAPE_AW-1:0];
        oor_a      = add_oor;
      end
      KIND_SUB_PTR: begin
        data_ptr_d = data_ptr_q - in_i.operand[TAPE_AW-1:0];
        oor_a      = sub_oor;
      end
      default: begin
        data_ptr_d = data_ptr_q;
        oor_a      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_ptr_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (in_fire) begin
        data_ptr_q <= data_ptr_d;
      end
    end
  end

  // Capture the word and the cell under the old pointer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_a;
      s1_opnd_q <= in_i.operand;
      s1_rd_q   <= in_i.read_data;
      s1_idx_q  <= data_ptr_q;
      s1_oor_q  <= oor_a;
      cell_q    <= tape_mem[data_ptr_q];
    end
  end

  // ---------------- Stage B: execute ----------------
  // The read missed a write made at the same edge; take it from the bypass.
  assign cur_byte = (fwd_valid_q && (fwd_addr_q == s1_idx_q)) ? fwd_data_q : cell_q;
  assign ip_inc   = ip_q + 1'b1;

  always_comb begin
    cell_new            = cur_byte;
    cell_we             = 1'b0;
    ip_d                = ip_q;
    push.valid          = s1_valid_q;
    push.data.out_byte  = '0;
    push.data.out_valid = 1'b0;
    push.data.status    = STAT_OK;
    case (s1_kind_q)
      KIND_END: begin
        push.data.status = STAT_HALT;
      end
      KIND_ADD_BYTE: begin
        cell_new = cur_byte + s1_opnd_q[BYTE_W-1:0];
        cell_we  = 1'b1;
        ip_d     = ip_inc;
      end
      KIND_SUB_BYTE: begin
        cell_new = cur_byte - s1_opnd_q[BYTE_W-1:0];
        cell_we  = 1'b1;
        ip_d     = ip_inc;
      end
      KIND_ADD_PTR, KIND_SUB_PTR: begin
        ip_d = ip_inc;
        if (s1_oor_q) begin
          push.data.status = STAT_PTR_OOR;
        end
      end
      KIND_WRITE: begin
        push.data.out_byte  = cur_byte;
        push.data.out_valid = 1'b1;
        ip_d                = ip_inc;
      end
      KIND_READ: begin
        cell_new = s1_rd_q;
        cell_we  = 1'b1;
        ip_d     = ip_inc;
      end
      KIND_JUMP_Z: begin
        ip_d = (cur_byte != '0) ? ip_inc : s1_opnd_q[PROG_AW-1:0];
      end
      KIND_JUMP: begin
        ip_d = s1_opnd_q[PROG_AW-1:0];
      end
      default: begin
        push.data.status = STAT_UNKNOWN;
      end
    endcase
    push.data.next_ip = IP_W'(ip_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q        <= '0;
      fwd_valid_q <= 1'b0;
    end else if (s1_valid_q) begin
      ip_q <= ip_d;
      if (cell_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && cell_we) begin
      fwd_addr_q <= s1_idx_q;
      fwd_data_q <= cell_new;
    end
  end

  // ---------------- Tape write port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign wr_en   = clr_q || (s1_valid_q && cell_we);
  assign wr_addr = clr_q ? clr_addr_q : s1_idx_q;
  assign wr_data = clr_q ? '0 : cell_new;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tape_mem[wr_addr] <= wr_data;
    end
  end

  // ---------------- Result queue ----------------
  tmbe_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .count_o (fifo_cnt),
    .out_o   (out_o)
  );

endmodule

// ===== bench/tb_tape_machine_bytecode_executor.sv =====
module tb_tape_machine_bytecode_executor;
  import tmbe_pkg::*;

  // Cycles with no word accepted on either channel before the run is called dead.
  // The clearing pass after reset alone keeps in_i.ready low while it writes every tape cell.
  localparam int unsigned QUIET_LIMIT = 4 * TAPE_DEPTH;
  // Cycles to keep watching the output once nothing is pending.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Length of the one long receiver hold that backs the pipe up into the input.
  localparam int unsigned LONG_HOLD = 300;
  // Items at the tail of the run with no idling on either side.
  localparam int unsigned CALM_TAIL = 300;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [OPND_W-1:0] operand;
    logic [BYTE_W-1:0] read_data;
    int unsigned       idle_after;  // sender gap cycles after this word
  } instr_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmbe_in_if  in_if ();
  tmbe_out_if out_if ();

  tape_machine_bytecode_executor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Machine image kept by the bench: tape, data pointer, instruction pointer.
  bit   [BYTE_W-1:0]  tape_img [TAPE_DEPTH];
  logic [TAPE_AW-1:0] data_ptr_img;
  logic [IP_W-1:0]    ip_img;

  instr_t  instr_q[$];        // words still to be offered
  result_t exec_results_q[$]; // results owed by the block, oldest first
  int unsigned n_items;
  int unsigned n_results;
  int unsigned err_count;

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $time, what);
    err_count++;
  endtask

  // Run one instruction on the bench image and return the result it owes.
  function automatic result_t exec_instr(input logic [KIND_W-1:0] kind,
                                         input logic [OPND_W-1:0] operand,
                                         input logic [BYTE_W-1:0] read_data);
    result_t          res;
    logic [IP_W-1:0]  ip_inc;
    logic [OPND_W:0]  ptr_sum;
    res.next_ip   = ip_img;
    res.out_byte  = '0;
    res.out_valid = 1'b0;
    res.status    = STAT_OK;
    ip_inc        = ip_img + 1'b1;  // wraps at PROG_DEPTH by width
    case (kind)
      KIND_END: begin
        res.status = STAT_HALT;
      end
      KIND_ADD_BYTE: begin
        tape_img[data_ptr_img] = tape_img[data_ptr_img] + operand[BYTE_W-1:0];
        res.next_ip = ip_inc;
      end
      KIND_SUB_BYTE: begin
        tape_img[data_ptr_img] = tape_img[data_ptr_img] - operand[BYTE_W-1:0];
        res.next_ip = ip_inc;
      end
      KIND_ADD_PTR: begin
        // Flag on the true sum leaving the tape, then wrap by masking.
        ptr_sum = {2'b00, data_ptr_img} + {1'b0, operand};
        if (ptr_sum >= TAPE_DEPTH) res.status = STAT_PTR_OOR;
        data_ptr_img = ptr_sum[TAPE_AW-1:0];
        res.next_ip  = ip_inc;
      end
      KIND_SUB_PTR: begin
        if (operand > data_ptr_img) res.status = STAT_PTR_OOR;
        data_ptr_img = data_ptr_img - operand[TAPE_AW-1:0];
        res.next_ip  = ip_inc;
      end
      KIND_WRITE: begin
        res.out_byte  = tape_img[data_ptr_img];
        res.out_valid = 1'b1;
        res.next_ip   = ip_inc;
      end
      KIND_READ: begin
        tape_img[data_ptr_img] = read_data;
        res.next_ip = ip_inc;
      end
      KIND_JUMP_Z: begin
        res.next_ip = (tape_img[data_ptr_img] != 8'h00) ? ip_inc : operand;
      end
      KIND_JUMP: begin
        res.next_ip = operand;
      end
      default: begin
        res.status = STAT_UNKNOWN;
      end
    endcase
    ip_img = res.next_ip;
    return res;
  endfunction

  task automatic add_instr(input logic [KIND_W-1:0] kind, input logic [OPND_W-1:0] operand,
                           input logic [BYTE_W-1:0] read_data, input int unsigned idle);
    instr_t it;
    it.kind       = kind;
    it.operand    = operand;
    it.read_data  = read_data;
    it.idle_after = idle;
    instr_q.push_back(it);
  endtask

  // Driver: offer words from instr_q, predict each one at the edge it is taken.
  int unsigned tx_idle_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.kind      <= '0;
      in_if.operand   <= '0;
      in_if.read_data <= '0;
      tx_idle_left    = 0;
    end else begin : tx
      instr_t it;
      if (in_if.valid && in_if.ready)
        exec_results_q.push_back(exec_instr(in_if.kind, in_if.operand, in_if.read_data));
      // Hold the word until taken; only then pick the next one or idle.
      if (!in_if.valid || in_if.ready) begin
        if (tx_idle_left != 0) begin
          tx_idle_left--;
          in_if.valid <= 1'b0;
        end else if (instr_q.size() != 0) begin
          it = instr_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.kind      <= it.kind;
          in_if.operand   <= it.operand;
          in_if.read_data <= it.read_data;
          tx_idle_left    = it.idle_after;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest prediction and drive
  // ready with random stall bursts plus one long hold.
  int unsigned rx_stall_left;
  int unsigned rx_mode;
  bit          long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready   <= 1'b0;
      rx_stall_left  = 0;
      rx_mode        = 0;
      long_hold_done = 1'b0;
    end else begin : rx
      result_t want;
      if (out_if.valid && out_if.ready) begin
        if (exec_results_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word: next_ip %h status %0d",
                                  out_if.next_ip, out_if.status));
        end else begin
          want = exec_results_q.pop_front();
          if (out_if.next_ip !== want.next_ip)
            flag_mismatch($sformatf("result %0d next_ip %h, want %h",
                                    n_results, out_if.next_ip, want.next_ip));
          if (out_if.out_byte !== want.out_byte)
            flag_mismatch($sformatf("result %0d out_byte %h, want %h",
                                    n_results, out_if.out_byte, want.out_byte));
          if (out_if.out_valid !== want.out_valid)
            flag_mismatch($sformatf("result %0d out_valid %b, want %b",
                                    n_results, out_if.out_valid, want.out_valid));
          if (out_if.status !== want.status)
            flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                    n_results, out_if.status, want.status));
        end
        n_results++;
        // Change stall density every 128 results: none, light or heavy.
        if (n_results % 128 == 0) rx_mode = $urandom_range(0, 2);
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && n_results >= 500) begin
        // Hold off long enough for the result queue to fill and stall in_i.
        long_hold_done = 1'b1;
        rx_stall_left  = LONG_HOLD - 1;
        out_if.ready   <= 1'b0;
      end else if (n_results + CALM_TAIL < n_items && rx_mode != 0 &&
                   $urandom_range(0, (rx_mode == 1) ? 9 : 2) == 0) begin
        rx_stall_left = $urandom_range(1, 10) - 1;
        out_if.ready  <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned          mode;
    int unsigned          pick;
    int unsigned          idle;
    logic [KIND_W-1:0]    kind;
    logic [OPND_W-1:0]    operand;

    // Put every input at a known value before the first edge.
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = '0;
    in_if.operand   = '0;
    in_if.read_data = '0;
    out_if.ready    = 1'b0;
    data_ptr_img    = '0;
    ip_img          = '0;
    n_results       = 0;
    err_count       = 0;
    quiet_cycles    = 0;

    // Directed words: byte wrap, pointer leaving the tape both ways, jump
    // taken and not taken, instruction pointer wrap, halt and unknown kinds.
    add_instr(KIND_END,      16'h0000, 8'h00, 0);
    add_instr(KIND_ADD_BYTE, 16'hFFFF, 8'hFF, 0); // only the low byte counts
    add_instr(KIND_WRITE,    16'hFFFF, 8'h00, 0);
    add_instr(KIND_ADD_BYTE, 16'h0101, 8'h00, 1); // cell wraps to zero
    add_instr(KIND_JUMP_Z,   16'hABCD, 8'h00, 0); // taken
    add_instr(KIND_SUB_BYTE, 16'hFF01, 8'h00, 0); // cell wraps below zero
    add_instr(KIND_JUMP_Z,   16'h1234, 8'h00, 0); // not taken
    add_instr(KIND_SUB_PTR,  16'h0001, 8'h00, 0); // below cell zero
    add_instr(KIND_READ,     16'h0000, 8'hA5, 0);
    add_instr(KIND_WRITE,    16'h0000, 8'h00, 2);
    add_instr(KIND_ADD_PTR,  16'h0001, 8'h00, 0); // past the last cell
    add_instr(KIND_ADD_PTR,  16'hFFFF, 8'h00, 0);
    add_instr(KIND_WRITE,    16'h0000, 8'h00, 0);
    add_instr(KIND_SUB_PTR,  16'hFFFF, 8'h00, 0);
    add_instr(KIND_ADD_PTR,  16'h7FFF, 8'h00, 0); // lands on the last cell
    add_instr(KIND_SUB_PTR,  16'h7FFF, 8'h00, 0); // back to zero exactly
    add_instr(KIND_READ,     16'h0000, 8'h00, 0);
    add_instr(KIND_READ,     16'h0000, 8'hFF, 0);
    add_instr(KIND_JUMP,     16'hFFFF, 8'h00, 0);
    add_instr(KIND_ADD_BYTE, 16'h0000, 8'h00, 0); // ip wraps to zero
    add_instr(4'd9,          16'h5555, 8'h55, 0);
    add_instr(4'd15,         16'hAAAA, 8'hAA, 0);
    add_instr(KIND_SUB_PTR,  16'h0000, 8'h00, 0);
    add_instr(KIND_ADD_PTR,  16'h0000, 8'h00, 0);
    add_instr(KIND_END,      16'hFFFF, 8'hFF, 0);

    // Random program: mostly tape work with short pointer moves, so cells are
    // hit back to back and revisited; sender idle density changes per block.
    for (int i = 0; i < 1800; i++) begin
      if (i % 100 == 0) mode = $urandom_range(0, 2);
      pick    = $urandom_range(0, 99);
      operand = OPND_W'($urandom_range(0, 16'hFFFF));
      if      (pick < 3)  kind = KIND_END;
      else if (pick < 6)  kind = KIND_W'($urandom_range(9, 15));
      else if (pick < 21) kind = KIND_ADD_BYTE;
      else if (pick < 34) kind = KIND_SUB_BYTE;
      else if (pick < 44) kind = KIND_ADD_PTR;
      else if (pick < 54) kind = KIND_SUB_PTR;
      else if (pick < 69) kind = KIND_WRITE;
      else if (pick < 79) kind = KIND_READ;
      else if (pick < 92) kind = KIND_JUMP_Z;
      else                kind = KIND_JUMP;
      if (kind == KIND_ADD_PTR || kind == KIND_SUB_PTR) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)      operand = OPND_W'($urandom_range(0, 3));
        else if (pick < 9) operand = OPND_W'($urandom_range(0, 255));
      end
      if (i + CALM_TAIL >= 1800 || mode == 0)
        idle = 0;
      else if ($urandom_range(0, (mode == 1) ? 9 : 2) == 0)
        idle = $urandom_range(1, 10);
      else
        idle = 0;
      add_instr(kind, operand, BYTE_W'($urandom_range(0, 255)), idle);
    end
    n_items = instr_q.size();

    // Reset once, released away from the rising edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every word to be taken and every result to arrive.
    while (instr_q.size() != 0 || in_if.valid || exec_results_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
